>>> rtl/kart_pkg.sv
// Shared types, constants and the measurement micro-programme of the angle and rate tracker.
package kart_pkg;

  localparam int DATA_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF  = 32;
  localparam int FIELD_W        = 48;
  localparam int PERIOD_W       = 47;
  localparam int APB_DW         = 64;
  localparam int APB_AW         = 6;
  localparam int STEP_W         = 6;

  typedef enum logic [2:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_PROCESS_NOISE = 3'd1,
    REG_MEAS_NOISE    = 3'd2,
    REG_INIT_ANGLE    = 3'd3,
    REG_INIT_RATE     = 3'd4,
    REG_INIT_VAR_ANG  = 3'd5,
    REG_INIT_COV      = 3'd6,
    REG_INIT_VAR_RATE = 3'd7
  } reg_idx_t;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_REINIT  = 1'b1;

  typedef enum logic [2:0] {
    OP_MUL, OP_MULSH1, OP_MULSH2, OP_DIV, OP_ADD, OP_SUB, OP_BRZ, OP_END
  } op_t;

  typedef enum logic [4:0] {
    V_DT, V_Q, V_R, V_Z, V_ONE, V_DT2, V_DT3, V_DT4, V_T, V_Q4, V_Q3, V_Q2,
    V_P11, V_P12, V_P21, V_P22, V_AP, V_S, V_Y, V_K1, V_K2, V_OMK,
    V_ANG, V_RATE, V_AA, V_AR, V_RA, V_RR
  } var_t;

  typedef struct packed {
    op_t  op;
    var_t a;
    var_t b;
    var_t dst;
  } uop_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_cmd_t;

  function automatic uop_t prog(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '{OP_END, V_T, V_T, V_T};
    unique case (step)
      6'd0:  u = '{OP_MUL,    V_DT,   V_DT,  V_DT2};
      6'd1:  u = '{OP_MUL,    V_DT2,  V_DT,  V_DT3};
      6'd2:  u = '{OP_MUL,    V_DT2,  V_DT2, V_DT4};
      6'd3:  u = '{OP_MULSH2, V_Q,    V_DT4, V_Q4};
      6'd4:  u = '{OP_MULSH1, V_Q,    V_DT3, V_Q3};
      6'd5:  u = '{OP_MUL,    V_Q,    V_DT2, V_Q2};
      6'd6:  u = '{OP_MUL,    V_DT,   V_RA,  V_T};
      6'd7:  u = '{OP_ADD,    V_AA,   V_T,   V_P11};
      6'd8:  u = '{OP_MUL,    V_DT,   V_RR,  V_T};
      6'd9:  u = '{OP_ADD,    V_AR,   V_T,   V_T};
      6'd10: u = '{OP_MUL,    V_DT,   V_T,   V_T};
      6'd11: u = '{OP_ADD,    V_P11,  V_T,   V_P11};
      6'd12: u = '{OP_ADD,    V_P11,  V_Q4,  V_P11};
      6'd13: u = '{OP_MUL,    V_RR,   V_DT,  V_T};
      6'd14: u = '{OP_ADD,    V_AR,   V_T,   V_P12};
      6'd15: u = '{OP_ADD,    V_P12,  V_Q3,  V_P12};
      6'd16: u = '{OP_ADD,    V_RA,   V_T,   V_P21};
      6'd17: u = '{OP_ADD,    V_P21,  V_Q3,  V_P21};
      6'd18: u = '{OP_ADD,    V_RR,   V_Q2,  V_P22};
      6'd19: u = '{OP_MUL,    V_RATE, V_DT,  V_T};
      6'd20: u = '{OP_ADD,    V_ANG,  V_T,   V_AP};
      6'd21: u = '{OP_ADD,    V_P11,  V_R,   V_S};
      6'd22: u = '{OP_BRZ,    V_S,    V_S,   V_S};
      6'd23: u = '{OP_SUB,    V_Z,    V_AP,  V_Y};
      6'd24: u = '{OP_DIV,    V_P11,  V_S,   V_K1};
      6'd25: u = '{OP_DIV,    V_P21,  V_S,   V_K2};
      6'd26: u = '{OP_SUB,    V_ONE,  V_K1,  V_OMK};
      6'd27: u = '{OP_MUL,    V_K1,   V_Y,   V_T};
      6'd28: u = '{OP_ADD,    V_AP,   V_T,   V_ANG};
      6'd29: u = '{OP_MUL,    V_K2,   V_Y,   V_T};
      6'd30: u = '{OP_ADD,    V_RATE, V_T,   V_RATE};
      6'd31: u = '{OP_MUL,    V_OMK,  V_P11, V_AA};
      6'd32: u = '{OP_MUL,    V_OMK,  V_P12, V_AR};
      6'd33: u = '{OP_MUL,    V_K2,   V_P11, V_T};
      6'd34: u = '{OP_SUB,    V_P21,  V_T,   V_RA};
      6'd35: u = '{OP_MUL,    V_K2,   V_P12, V_T};
      6'd36: u = '{OP_SUB,    V_P22,  V_T,   V_RR};
      default: u = '{OP_END, V_T, V_T, V_T};
    endcase
    return u;
  endfunction

endpackage

>>> rtl/kart_if.sv
// Valid/ready channel interfaces for requests and results.
interface kart_req_if import kart_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [FIELD_W-1:0] angle_measured;
  modport source (output valid, req_type, angle_measured, input ready);
  modport sink (input valid, req_type, angle_measured, output ready);
endinterface

interface kart_rsp_if import kart_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] angle_estimate;
  logic signed [FIELD_W-1:0] rate_estimate;
  modport source (output valid, angle_estimate, rate_estimate, input ready);
  modport sink (input valid, angle_estimate, rate_estimate, output ready);
endinterface

>>> rtl/kart_mdu.sv
// Shared bit-serial saturating fixed-point multiplier and divider.
module kart_mdu import kart_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mdu_cmd_t                     cmd,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         done
);
  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int QW = W + FRAC_BITS;
  localparam int MW = (PW > QW + 1) ? PW : QW + 1;
  localparam int CW = $clog2(QW + 1);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} ustate_t;

  ustate_t         state;
  logic            neg;
  logic            is_div;
  logic [W-1:0]    ma, mb;
  logic [PW-1:0]   acc;
  logic [QW-1:0]   quo, num;
  logic [W-1:0]    rem;
  logic [CW-1:0]   cnt;

  logic [W-1:0]    mag_a, mag_b;
  logic [W:0]      sum, rem_sh;
  logic            ge, rnd;
  logic [MW-1:0]   m, lim;
  logic [W-1:0]    m_sat;

  always_comb begin
    mag_a  = a[W-1] ? W'(0) - W'(a) : W'(a);
    mag_b  = b[W-1] ? W'(0) - W'(b) : W'(b);
    sum    = {1'b0, acc[PW-1:W]} + (mb[0] ? {1'b0, ma} : {(W+1){1'b0}});
    rem_sh = {rem, num[QW-1]};
    ge     = rem_sh >= {1'b0, mb};
    rnd    = {rem, 1'b0} >= {1'b0, mb};
    if (is_div) begin
      m = MW'(quo) + MW'(rnd);
    end else begin
      m = (MW'(acc) + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
    lim   = (MW'(1) << (W - 1)) - MW'(!neg);
    m_sat = (m > lim) ? lim[W-1:0] : m[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == U_FIN);
      unique case (state)
        U_IDLE: begin
          if (cmd.start) begin
            neg    <= a[W-1] ^ b[W-1];
            is_div <= cmd.is_div;
            ma     <= mag_a;
            mb     <= mag_b;
            acc    <= '0;
            rem    <= '0;
            quo    <= '0;
            num    <= {mag_a, {FRAC_BITS{1'b0}}};
            cnt    <= '0;
            state  <= cmd.is_div ? U_DIV : U_MUL;
          end
        end
        U_MUL: begin
          acc <= {sum, acc[W-1:1]};
          mb  <= mb >> 1;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(W - 1)) state <= U_FIN;
        end
        U_DIV: begin
          rem <= ge ? W'(rem_sh - {1'b0, mb}) : rem_sh[W-1:0];
          quo <= {quo[QW-2:0], ge};
          num <= num << 1;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(QW - 1)) state <= U_FIN;
        end
        U_FIN: begin
          result <= neg ? W'(0) - m_sat : m_sat;
          state  <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/kalman_angle_rate_tracker.sv
// Top level of the two-state angle and rate Kalman tracker with its sequencer.
//
//   port    kind         beat / access
//   req     valid/ready  req_type, angle_measured
//   rsp     valid/ready  angle_estimate, rate_estimate
//   apb     APB r/w      eight registers at byte address 8*index, 64-bit data
//
// A reinitialise request loads the initial registers and then offers its result beat via S_OUT.
// A measurement runs 37 micro-steps, 17 multiplies and 2 divides, on one shared serial unit.
// A zero innovation denominator ends the work early with the state unchanged.
// req.ready is high only while no request is in progress; a stalled result beat holds.
// Reset is synchronous and loads the register reset values and unit covariance.
module kalman_angle_rate_tracker import kart_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  kart_req_if.sink          req,
  kart_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);
  localparam int W  = DATA_WIDTH;
  localparam int EW = ((W > FIELD_W) ? W : FIELD_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} state_t;
  typedef logic signed [W-1:0] val_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic [PERIOD_W-1:0] cfg_dt, cfg_q, cfg_r;
  logic [FIELD_W-1:0]  cfg_ang, cfg_rate, cfg_vaa, cfg_cov, cfg_vrr;
  val_t ang, rate, aa, ar, ra, rr;
  val_t z, dt2, dt3, dt4, t, q4, q3, q2, p11, p12, p21, p22, ap, s, y, k1, k2, omk;

  uop_t     u;
  val_t     opa, opb, wdata, mdu_res, alu_res;
  logic     wen, mdu_done, wr_cfg;
  mdu_cmd_t cmd;
  reg_idx_t widx, ridx;

  function automatic val_t clamp_ext(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] maxe, mine;
    maxe = EW'($signed({1'b0, {(W-1){1'b1}}}));
    mine = -maxe - EW'(1);
    if (x > maxe) return maxe[W-1:0];
    if (x < mine) return mine[W-1:0];
    return x[W-1:0];
  endfunction

  function automatic val_t from_u47(input logic [PERIOD_W-1:0] v);
    return clamp_ext(EW'($signed({1'b0, v})));
  endfunction

  function automatic val_t from_s48(input logic [FIELD_W-1:0] v);
    return clamp_ext(EW'($signed(v)));
  endfunction

  function automatic val_t sat_addsub(input val_t x, input val_t yv, input logic sub);
    logic signed [W:0] r;
    r = sub ? (W+1)'(x) - (W+1)'(yv) : (W+1)'(x) + (W+1)'(yv);
    if (r[W] != r[W-1]) return r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return r[W-1:0];
  endfunction

  function automatic val_t pick(input var_t v, input val_t zv, input val_t one);
    val_t r;
    r = '0;
    unique case (v)
      V_DT:   r = from_u47(cfg_dt);
      V_Q:    r = from_u47(cfg_q);
      V_R:    r = from_u47(cfg_r);
      V_Z:    r = zv;
      V_ONE:  r = one;
      V_DT2:  r = dt2;
      V_DT3:  r = dt3;
      V_DT4:  r = dt4;
      V_T:    r = t;
      V_Q4:   r = q4;
      V_Q3:   r = q3;
      V_Q2:   r = q2;
      V_P11:  r = p11;
      V_P12:  r = p12;
      V_P21:  r = p21;
      V_P22:  r = p22;
      V_AP:   r = ap;
      V_S:    r = s;
      V_Y:    r = y;
      V_K1:   r = k1;
      V_K2:   r = k2;
      V_OMK:  r = omk;
      V_ANG:  r = ang;
      V_RATE: r = rate;
      V_AA:   r = aa;
      V_AR:   r = ar;
      V_RA:   r = ra;
      V_RR:   r = rr;
      default: r = '0;
    endcase
    return r;
  endfunction

  val_t one_sat;
  assign one_sat = clamp_ext(EW'(1) <<< FRAC_BITS);

  always_comb begin
    u       = prog(step);
    opa     = pick(u.a, z, one_sat);
    opb     = pick(u.b, z, one_sat);
    alu_res = sat_addsub(opa, opb, u.op == OP_SUB);
    cmd.start  = (state == S_EXEC) &&
                 (u.op == OP_MUL || u.op == OP_MULSH1 || u.op == OP_MULSH2 || u.op == OP_DIV);
    cmd.is_div = (u.op == OP_DIV);
    wen   = 1'b0;
    wdata = alu_res;
    if (state == S_EXEC && (u.op == OP_ADD || u.op == OP_SUB)) begin
      wen = 1'b1;
    end else if (state == S_WAIT && mdu_done) begin
      wen = 1'b1;
      unique case (u.op)
        OP_MULSH1: wdata = {1'b0, mdu_res[W-1:1]};
        OP_MULSH2: wdata = {2'b00, mdu_res[W-1:2]};
        default:   wdata = mdu_res;
      endcase
    end
  end

  kart_mdu #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mdu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .a      (opa),
    .b      (opb),
    .result (mdu_res),
    .done   (mdu_done)
  );

  assign req.ready = (state == S_IDLE);
  assign pready    = 1'b1;
  assign wr_cfg    = psel && penable && pwrite;
  assign widx      = reg_idx_t'(paddr[APB_AW-1:3]);
  assign ridx      = reg_idx_t'(paddr[APB_AW-1:3]);

  always_comb begin
    unique case (ridx)
      REG_SAMPLE_PERIOD: prdata = APB_DW'(cfg_dt);
      REG_PROCESS_NOISE: prdata = APB_DW'(cfg_q);
      REG_MEAS_NOISE:    prdata = APB_DW'(cfg_r);
      REG_INIT_ANGLE:    prdata = APB_DW'($signed(cfg_ang));
      REG_INIT_RATE:     prdata = APB_DW'($signed(cfg_rate));
      REG_INIT_VAR_ANG:  prdata = APB_DW'($signed(cfg_vaa));
      REG_INIT_COV:      prdata = APB_DW'($signed(cfg_cov));
      REG_INIT_VAR_RATE: prdata = APB_DW'($signed(cfg_vrr));
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      rsp.valid <= 1'b0;
      cfg_dt    <= PERIOD_W'(4294967);
      cfg_q     <= PERIOD_W'(4294967);
      cfg_r     <= PERIOD_W'(4294967);
      cfg_ang   <= '0;
      cfg_rate  <= '0;
      cfg_vaa   <= FIELD_W'(64'd4294967296);
      cfg_cov   <= '0;
      cfg_vrr   <= FIELD_W'(64'd4294967296);
      ang       <= '0;
      rate      <= '0;
      aa        <= one_sat;
      ar        <= '0;
      ra        <= '0;
      rr        <= one_sat;
    end else begin
      if (wr_cfg) begin
        unique case (widx)
          REG_SAMPLE_PERIOD: cfg_dt   <= pwdata[PERIOD_W-1:0];
          REG_PROCESS_NOISE: cfg_q    <= pwdata[PERIOD_W-1:0];
          REG_MEAS_NOISE:    cfg_r    <= pwdata[PERIOD_W-1:0];
          REG_INIT_ANGLE:    cfg_ang  <= pwdata[FIELD_W-1:0];
          REG_INIT_RATE:     cfg_rate <= pwdata[FIELD_W-1:0];
          REG_INIT_VAR_ANG:  cfg_vaa  <= pwdata[FIELD_W-1:0];
          REG_INIT_COV:      cfg_cov  <= pwdata[FIELD_W-1:0];
          REG_INIT_VAR_RATE: cfg_vrr  <= pwdata[FIELD_W-1:0];
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready && state != S_OUT) rsp.valid <= 1'b0;

      if (wen) begin
        unique case (u.dst)
          V_DT2:  dt2  <= wdata;
          V_DT3:  dt3  <= wdata;
          V_DT4:  dt4  <= wdata;
          V_T:    t    <= wdata;
          V_Q4:   q4   <= wdata;
          V_Q3:   q3   <= wdata;
          V_Q2:   q2   <= wdata;
          V_P11:  p11  <= wdata;
          V_P12:  p12  <= wdata;
          V_P21:  p21  <= wdata;
          V_P22:  p22  <= wdata;
          V_AP:   ap   <= wdata;
          V_S:    s    <= wdata;
          V_Y:    y    <= wdata;
          V_K1:   k1   <= wdata;
          V_K2:   k2   <= wdata;
          V_OMK:  omk  <= wdata;
          V_ANG:  ang  <= wdata;
          V_RATE: rate <= wdata;
          V_AA:   aa   <= wdata;
          V_AR:   ar   <= wdata;
          V_RA:   ra   <= wdata;
          V_RR:   rr   <= wdata;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            step <= '0;
            if (req.req_type == REQ_REINIT) begin
              ang   <= from_s48(cfg_ang);
              rate  <= from_s48(cfg_rate);
              aa    <= from_s48(cfg_vaa);
              ar    <= from_s48(cfg_cov);
              ra    <= from_s48(cfg_cov);
              rr    <= from_s48(cfg_vrr);
              state <= S_OUT;
            end else begin
              z     <= from_s48(req.angle_measured);
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          unique case (u.op)
            OP_ADD, OP_SUB: step <= step + STEP_W'(1);
            OP_BRZ: begin
              if (s == '0) state <= S_OUT;
              else step <= step + STEP_W'(1);
            end
            OP_END: state <= S_OUT;
            default: state <= S_WAIT;
          endcase
        end
        S_WAIT: begin
          if (mdu_done) begin
            step  <= step + STEP_W'(1);
            state <= S_EXEC;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.angle_estimate <= FIELD_W'(EW'(ang));
            rsp.rate_estimate  <= FIELD_W'(EW'(rate));
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/kart_checker.sv
// Port-level checks of the tracker, bound to the top level.
module kart_checker import kart_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [FIELD_W-1:0] angle_estimate
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request port stayed ready after a beat was accepted");

  a_result_follows_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result beat appeared without a request in progress");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(angle_estimate))
    else $error("result payload changed while stalled");

endmodule

bind kalman_angle_rate_tracker kart_checker u_kart_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .angle_estimate (rsp.angle_estimate)
);
